[sv/fdc_pkg.sv]
// Shared constants, types and the CRC-32 byte update for the frame deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

    // Frame layout.
    localparam int MAGIC_BYTES  = 4;
    localparam int HEADER_BYTES = 68;
    localparam int HCNT_W       = $clog2(HEADER_BYTES);

    // Channel widths.
    localparam int BYTE_W        = 8;
    localparam int FIELD_CODE_W  = 4;
    localparam int FIELD_VALUE_W = 64;
    localparam int STATUS_W      = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int VERSION_W     = 16;
    localparam int LENGTH_W      = 32;
    localparam int CRC_W         = 32;
    localparam int ID_COUNT      = 6;

    // CRC-32, reflected form.
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VERSION     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY_LENGTH = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HSIZE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CRC         = 3'd5;

    // Field codes of result items.
    localparam logic [FIELD_CODE_W-1:0] FC_VERSION   = 4'd0;
    localparam logic [FIELD_CODE_W-1:0] FC_TYPE      = 4'd1;
    localparam logic [FIELD_CODE_W-1:0] FC_FLAGS     = 4'd2;
    localparam logic [FIELD_CODE_W-1:0] FC_REQUEST   = 4'd3;
    localparam logic [FIELD_CODE_W-1:0] FC_SESSION   = 4'd4;
    localparam logic [FIELD_CODE_W-1:0] FC_USER      = 4'd5;
    localparam logic [FIELD_CODE_W-1:0] FC_DEVICE    = 4'd6;
    localparam logic [FIELD_CODE_W-1:0] FC_TIMESTAMP = 4'd7;
    localparam logic [FIELD_CODE_W-1:0] FC_SEQUENCE  = 4'd8;
    localparam logic [FIELD_CODE_W-1:0] FC_LENGTH    = 4'd9;
    localparam logic [FIELD_CODE_W-1:0] FC_CHECKSUM  = 4'd10;
    localparam logic [FIELD_CODE_W-1:0] FC_BODY      = 4'd11;

    // Command kinds passed from the front to the back.
    localparam logic [1:0] CMD_HDR_ERR = 2'd0;
    localparam logic [1:0] CMD_HDR     = 2'd1;
    localparam logic [1:0] CMD_BODY    = 2'd2;

    // Command queue size.
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued command: a finished header or one body byte.
    typedef struct packed {
        logic [1:0]          kind;
        logic [BYTE_W-1:0]   data;
        logic                eof;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    // Header fields held for the back while it emits them.
    typedef struct packed {
        logic [VERSION_W-1:0]                  version;
        logic [15:0]                           ftype;
        logic [15:0]                           flags;
        logic [ID_COUNT-1:0][FIELD_VALUE_W-1:0] ids;
        logic [LENGTH_W-1:0]                   length;
        logic [CRC_W-1:0]                      cksum;
    } t_hdr;

    // One byte of reflected CRC-32.
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/fdc_in_if.sv]
// Input byte channel of the frame deframer: valid, ready and one byte.
// Depends on fdc_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface fdc_in_if;
    import fdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

[sv/fdc_out_if.sv]
// Result channel of the frame deframer: valid, ready and one result item.
// Depends on fdc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fdc_out_if;
    import fdc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FIELD_CODE_W-1:0]  field_code;
    logic [FIELD_VALUE_W-1:0] field_value;
    logic                     end_of_frame;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output field_code, output field_value,
                    output end_of_frame, output status, input ready);
    modport sink   (input valid, input field_code, input field_value,
                    input end_of_frame, input status, output ready);
endinterface

`default_nettype wire

[sv/fdc_cfg_if.sv]
// Configuration write channel of the frame deframer: valid, ready, index, data.
// Depends on fdc_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface fdc_cfg_if;
    import fdc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/fdc_front.sv]
// Front of the deframer: configuration registers, header collection and checks,
// body CRC. Pushes one command per finished header or body byte.
// Depends on fdc_pkg, fdc_in_if and fdc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module fdc_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    fdc_in_if.sink         i_byte,
    fdc_cfg_if.sink        i_cfg,
    output logic           o_push,
    output fdc_pkg::t_cmd  o_cmd,
    input  wire            i_q_full,
    output fdc_pkg::t_hdr  o_hdr,
    input  wire            i_hdr_done
);
    import fdc_pkg::*;

    // Phase codes.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    localparam int HB_BITS   = HEADER_BYTES * BYTE_W;
    localparam int OFS_VER   = MAGIC_BYTES;
    localparam int OFS_HSIZE = MAGIC_BYTES + 2;
    localparam int OFS_TYPE  = MAGIC_BYTES + 4;
    localparam int OFS_FLAGS = MAGIC_BYTES + 6;
    localparam int OFS_IDS   = MAGIC_BYTES + 8;
    localparam int OFS_LEN   = MAGIC_BYTES + 56;
    localparam int OFS_CKSUM = MAGIC_BYTES + 60;
    localparam int MAGIC_W   = MAGIC_BYTES * BYTE_W;
    localparam logic [HCNT_W-1:0] LAST_CNT = HCNT_W'(HEADER_BYTES - 1);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_magic;
    logic [VERSION_W-1:0]  r_max_version;
    logic [LENGTH_W-1:0]   r_max_length;

    // Frame state.
    logic [1:0]             r_phase, n_phase;
    logic [HCNT_W-1:0]      r_count, n_count;
    logic [HB_BITS-BYTE_W-1:0] r_shift;
    logic [LENGTH_W-1:0]    r_remaining, n_remaining;
    logic [CRC_W-1:0]       r_crc, n_crc;
    logic [CRC_W-1:0]       r_expected, n_expected;
    logic                   r_busy, n_busy;
    t_hdr                   r_hdr;

    logic [HB_BITS-1:0]     w_bits;
    logic                   w_last;
    logic                   w_need_push;
    logic                   w_accept;
    logic                   w_load;
    logic [STATUS_W-1:0]    w_err;
    logic [VERSION_W-1:0]   w_version;
    logic [15:0]            w_hsize;
    logic [LENGTH_W-1:0]    w_length;
    logic [CRC_W-1:0]       w_cksum;
    logic [CRC_W-1:0]       w_crc_byte;
    t_hdr                   w_hdr;

    assign i_cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic       <= '0;
            r_max_version <= VERSION_W'(1);
            r_max_length  <= LENGTH_W'(1048576);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAGIC_WORD:      r_magic       <= i_cfg.data;
                CFG_MAX_VERSION:     r_max_version <= i_cfg.data[VERSION_W-1:0];
                CFG_MAX_BODY_LENGTH: r_max_length  <= i_cfg.data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole header as it stands on its last byte, first byte most significant.
    assign w_bits    = {r_shift, i_byte.byte_in};
    assign w_version = w_bits[(HEADER_BYTES - OFS_VER - 2) * BYTE_W +: 16];
    assign w_hsize   = w_bits[(HEADER_BYTES - OFS_HSIZE - 2) * BYTE_W +: 16];
    assign w_length  = w_bits[(HEADER_BYTES - OFS_LEN - 4) * BYTE_W +: 32];
    assign w_cksum   = w_bits[(HEADER_BYTES - OFS_CKSUM - 4) * BYTE_W +: 32];

    always_comb begin
        w_hdr.version = w_version;
        w_hdr.ftype   = w_bits[(HEADER_BYTES - OFS_TYPE - 2) * BYTE_W +: 16];
        w_hdr.flags   = w_bits[(HEADER_BYTES - OFS_FLAGS - 2) * BYTE_W +: 16];
        for (int k = 0; k < ID_COUNT; k++) begin
            w_hdr.ids[k] = w_bits[(HEADER_BYTES - OFS_IDS - 8 * k - 8) * BYTE_W +: 64];
        end
        w_hdr.length  = w_length;
        w_hdr.cksum   = w_cksum;
    end

    // Header checks in priority order.
    always_comb begin
        if (w_bits[HB_BITS-1 -: MAGIC_W] != r_magic[MAGIC_W-1:0]) begin
            w_err = ST_BAD_MAGIC;
        end else if (w_hsize != 16'(HEADER_BYTES)) begin
            w_err = ST_BAD_HSIZE;
        end else if (w_version == '0 || w_version > r_max_version) begin
            w_err = ST_BAD_VERSION;
        end else if (w_length > r_max_length) begin
            w_err = ST_TOO_LONG;
        end else begin
            w_err = ST_OK;
        end
    end

    // Handshake: stall when a command cannot go out or a header ends while busy.
    assign w_last      = (r_phase == PH_HEADER) && (r_count == LAST_CNT);
    assign w_need_push = w_last || (r_phase == PH_BODY);
    assign i_byte.ready = !(w_need_push && i_q_full) && !(w_last && r_busy);
    assign w_accept    = i_byte.valid && i_byte.ready;
    assign w_crc_byte  = crc32_byte(r_crc, i_byte.byte_in);
    assign w_load      = w_accept && w_last && (w_err == ST_OK);

    // Next state and the command for this byte.
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_remaining = r_remaining;
        n_crc       = r_crc;
        n_expected  = r_expected;
        n_busy      = w_load ? 1'b1 : (i_hdr_done ? 1'b0 : r_busy);
        o_push      = 1'b0;
        o_cmd.kind   = CMD_BODY;
        o_cmd.data   = i_byte.byte_in;
        o_cmd.eof    = 1'b0;
        o_cmd.status = ST_OK;
        if (w_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (w_last) begin
                        o_push  = 1'b1;
                        n_count = '0;
                        if (w_err != ST_OK) begin
                            o_cmd.kind   = CMD_HDR_ERR;
                            o_cmd.eof    = 1'b1;
                            o_cmd.status = w_err;
                            n_phase      = PH_ERROR;
                        end else begin
                            o_cmd.kind = CMD_HDR;
                            n_crc      = CRC_ONES;
                            n_expected = w_cksum;
                            if (w_length == '0) begin
                                o_cmd.eof    = 1'b1;
                                o_cmd.status = (w_cksum == '0) ? ST_OK : ST_CRC;
                                n_remaining  = '0;
                            end else begin
                                n_remaining = w_length;
                                n_phase     = PH_BODY;
                            end
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                PH_BODY: begin
                    o_push      = 1'b1;
                    n_crc       = w_crc_byte;
                    n_remaining = r_remaining - 1'b1;
                    if (r_remaining == LENGTH_W'(1)) begin
                        // Last body byte: check the CRC and start a new frame.
                        o_cmd.eof    = 1'b1;
                        o_cmd.status = ((w_crc_byte ^ CRC_ONES) == r_expected) ?
                                       ST_OK : ST_CRC;
                        n_phase      = PH_HEADER;
                        n_count      = '0;
                        n_crc        = CRC_ONES;
                    end
                end
                default: ;
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_remaining <= '0;
            r_crc       <= CRC_ONES;
            r_expected  <= '0;
            r_busy      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_crc       <= n_crc;
            r_expected  <= n_expected;
            r_busy      <= n_busy;
        end
    end

    // Header shift line and the held header record.
    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_HEADER) begin
            r_shift <= w_bits[HB_BITS-BYTE_W-1:0];
        end
        if (w_load) begin
            r_hdr <= w_hdr;
        end
    end

    assign o_hdr = r_hdr;

endmodule

`default_nettype wire

[sv/fdc_queue.sv]
// Command queue between the deframer front and back, first in, first out.
// Depends on fdc_pkg for the command type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module fdc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire fdc_pkg::t_cmd  i_data,
    output logic                o_full,
    output logic                o_valid,
    output fdc_pkg::t_cmd       o_data,
    input  wire                 i_pop
);
    import fdc_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[sv/fdc_back.sv]
// Back of the deframer: turns queued commands into result items, eleven for a
// good header and one otherwise. Depends on fdc_pkg and fdc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module fdc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  wire fdc_pkg::t_cmd  i_q_data,
    output logic                o_q_pop,
    input  wire fdc_pkg::t_hdr  i_hdr,
    output logic                o_hdr_done,
    fdc_out_if.source           o_field
);
    import fdc_pkg::*;

    logic                    r_valid;
    t_cmd                    r_cmd;
    logic [FIELD_CODE_W-1:0] r_idx;
    logic                    w_last;
    logic                    w_taken;
    logic [FIELD_VALUE_W-1:0] w_hdr_value;

    assign w_last  = (r_cmd.kind != CMD_HDR) || (r_idx == FC_CHECKSUM);
    assign w_taken = r_valid && o_field.ready;
    assign o_q_pop = i_q_valid && (!r_valid || (o_field.ready && w_last));
    assign o_hdr_done = w_taken && (r_cmd.kind == CMD_HDR) && (r_idx == FC_CHECKSUM);

    // Header field selected by the item index.
    always_comb begin
        case (r_idx)
            FC_VERSION:   w_hdr_value = FIELD_VALUE_W'(i_hdr.version);
            FC_TYPE:      w_hdr_value = FIELD_VALUE_W'(i_hdr.ftype);
            FC_FLAGS:     w_hdr_value = FIELD_VALUE_W'(i_hdr.flags);
            FC_REQUEST:   w_hdr_value = i_hdr.ids[0];
            FC_SESSION:   w_hdr_value = i_hdr.ids[1];
            FC_USER:      w_hdr_value = i_hdr.ids[2];
            FC_DEVICE:    w_hdr_value = i_hdr.ids[3];
            FC_TIMESTAMP: w_hdr_value = i_hdr.ids[4];
            FC_SEQUENCE:  w_hdr_value = i_hdr.ids[5];
            FC_LENGTH:    w_hdr_value = FIELD_VALUE_W'(i_hdr.length);
            FC_CHECKSUM:  w_hdr_value = FIELD_VALUE_W'(i_hdr.cksum);
            default:      w_hdr_value = '0;
        endcase
    end

    // Result item for the current command and index.
    always_comb begin
        o_field.valid = r_valid;
        case (r_cmd.kind)
            CMD_HDR: begin
                o_field.field_code   = r_idx;
                o_field.field_value  = w_hdr_value;
                o_field.end_of_frame = (r_idx == FC_CHECKSUM) ? r_cmd.eof : 1'b0;
                o_field.status       = (r_idx == FC_CHECKSUM) ? r_cmd.status : ST_OK;
            end
            CMD_BODY: begin
                o_field.field_code   = FC_BODY;
                o_field.field_value  = FIELD_VALUE_W'(r_cmd.data);
                o_field.end_of_frame = r_cmd.eof;
                o_field.status       = r_cmd.status;
            end
            default: begin
                o_field.field_code   = FC_VERSION;
                o_field.field_value  = '0;
                o_field.end_of_frame = 1'b1;
                o_field.status       = r_cmd.status;
            end
        endcase
    end

    // Current command and item index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_taken) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
    end

endmodule

`default_nettype wire

[sv/frame_deframer_crc32.sv]
// Top level of the length-prefixed frame deframer with CRC-32 body check.
// Depends on fdc_pkg, the channel interfaces, fdc_front, fdc_queue and fdc_back.
//
//   Channel  Direction  Transfer carries
//   i_byte   in         byte_in: one byte of the frame stream
//   o_field  out        field_code, field_value, end_of_frame, status
//   i_cfg    in         index, data: write to magic_word, max_version, max_body_length
//
// One byte is taken per cycle. A good header yields eleven items and each body
// byte one; the header burst drains through the 16-entry command queue while
// body bytes keep arriving. Input stalls only when the queue is full, or when a
// header completes while the previous header's items are still being emitted.
// Results pass through the command queue and the back's command register. Reset
// is synchronous, active low, and no clearing pass is needed; after a header error the block stays silent.
`timescale 1ns / 1ps
`default_nettype none

module frame_deframer_crc32 (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fdc_in_if.sink     i_byte,
    fdc_out_if.source  o_field,
    fdc_cfg_if.sink    i_cfg
);
    import fdc_pkg::*;

    logic  w_push;
    t_cmd  w_push_cmd;
    logic  w_q_full;
    logic  w_q_valid;
    t_cmd  w_q_data;
    logic  w_q_pop;
    t_hdr  w_hdr;
    logic  w_hdr_done;

    // Front: collect, check and run the CRC.
    fdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_cfg      (i_cfg),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_q_full   (w_q_full),
        .o_hdr      (w_hdr),
        .i_hdr_done (w_hdr_done)
    );

    // Command queue.
    fdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    // Back: emit result items.
    fdc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_q_data),
        .o_q_pop    (w_q_pop),
        .i_hdr      (w_hdr),
        .o_hdr_done (w_hdr_done),
        .o_field    (o_field)
    );

endmodule

`default_nettype wire
